// ----- design/brfb_pkg.sv -----
// Shared constants, command codes and inter-module types for the byte ring FIFO.
`timescale 1ns / 1ps
package brfb_pkg;

  localparam int RING_BYTES = 1024;
  localparam int MAX_BURST  = 8;
  localparam int PTR_W      = $clog2(RING_BYTES);
  localparam int NUM_LANES  = 8;
  localparam int LANE_W     = $clog2(NUM_LANES);
  localparam int ROW_W      = PTR_W - LANE_W;
  localparam int ROWS       = RING_BYTES / NUM_LANES;
  localparam int CMD_W      = 3;
  localparam int LEN_W      = 4;
  localparam int DATA_W     = 64;
  localparam int CNT_W      = 10;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT       = 3'd0,
    CMD_PUT_EXACT = 3'd1,
    CMD_GET       = 3'd2,
    CMD_GET_EXACT = 3'd3,
    CMD_FLUSH     = 3'd4
  } cmd_t;

  // one byte-bank access
  typedef struct packed {
    logic             we;
    logic             re;
    logic [ROW_W-1:0] row;
    logic [7:0]       wbyte;
  } lane_req_t;

  // per-beat result bookkeeping that travels alongside the bank access
  typedef struct packed {
    logic              valid;
    logic              is_get;
    logic [LEN_W-1:0]  moved;
    logic              refused;
    logic [CNT_W-1:0]  fill;
    logic [CNT_W-1:0]  free;
    logic [LANE_W-1:0] rot;
  } res_info_t;

endpackage

// ----- design/brfb_lane.sv -----
// One byte bank of the ring: one write and one registered read per cycle.
`timescale 1ns / 1ps
module brfb_lane (
  input  logic                clk,
  input  brfb_pkg::lane_req_t req,
  output logic [7:0]          rdata
);

  logic [7:0] mem [brfb_pkg::ROWS];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.row] <= req.wbyte;
    end
    if (req.re) begin
      rdata_r <= mem[req.row];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/brfb_ctrl.sv -----
// Pointer control: decodes the command, sizes the beat and fans it out to the lanes.
`timescale 1ns / 1ps
module brfb_ctrl (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     accept,
  input  logic [brfb_pkg::CMD_W-1:0]               command,
  input  logic [brfb_pkg::LEN_W-1:0]               burst_length,
  input  logic [brfb_pkg::DATA_W-1:0]              write_data,
  output brfb_pkg::lane_req_t [brfb_pkg::NUM_LANES-1:0] lane_req,
  output brfb_pkg::res_info_t                      info
);

  logic [brfb_pkg::PTR_W-1:0] wp_r, wp_nxt;
  logic [brfb_pkg::PTR_W-1:0] rp_r, rp_nxt;
  brfb_pkg::lane_req_t [brfb_pkg::NUM_LANES-1:0] req_r, req_nxt;
  brfb_pkg::res_info_t info_r, info_nxt;

  logic [brfb_pkg::PTR_W-1:0] fill_now, free_now, fill_after, base;
  logic [brfb_pkg::LEN_W-1:0] len_c, moved;
  logic                       is_put, is_get, refused, flush;
  logic [brfb_pkg::PTR_W+brfb_pkg::CNT_W-1:0] fill_ext, free_ext;

  always_comb begin
    logic [brfb_pkg::LANE_W-1:0] k;
    logic [brfb_pkg::PTR_W-1:0]  addr;

    fill_now = wp_r - rp_r;
    free_now = rp_r - wp_r - brfb_pkg::PTR_W'(1);
    len_c    = (burst_length > brfb_pkg::LEN_W'(brfb_pkg::MAX_BURST)) ?
               brfb_pkg::LEN_W'(brfb_pkg::MAX_BURST) : burst_length;
    moved    = '0;
    is_put   = 1'b0;
    is_get   = 1'b0;
    refused  = 1'b0;
    flush    = 1'b0;

    unique case (brfb_pkg::cmd_t'(command))
      brfb_pkg::CMD_PUT: begin
        is_put = 1'b1;
        moved  = (free_now < brfb_pkg::PTR_W'(len_c)) ?
                 brfb_pkg::LEN_W'(free_now) : len_c;
      end
      brfb_pkg::CMD_PUT_EXACT: begin
        if (free_now >= brfb_pkg::PTR_W'(len_c)) begin
          is_put = 1'b1;
          moved  = len_c;
        end else begin
          refused = 1'b1;
        end
      end
      brfb_pkg::CMD_GET: begin
        is_get = 1'b1;
        moved  = (fill_now < brfb_pkg::PTR_W'(len_c)) ?
                 brfb_pkg::LEN_W'(fill_now) : len_c;
      end
      brfb_pkg::CMD_GET_EXACT: begin
        if (fill_now >= brfb_pkg::PTR_W'(len_c)) begin
          is_get = 1'b1;
          moved  = len_c;
        end else begin
          refused = 1'b1;
        end
      end
      brfb_pkg::CMD_FLUSH: begin
        flush = 1'b1;
      end
      default: begin
      end
    endcase

    wp_nxt = wp_r;
    rp_nxt = rp_r;
    if (accept) begin
      if (flush) begin
        wp_nxt = '0;
        rp_nxt = '0;
      end else if (is_put) begin
        wp_nxt = wp_r + brfb_pkg::PTR_W'(moved);
      end else if (is_get) begin
        rp_nxt = rp_r + brfb_pkg::PTR_W'(moved);
      end
    end

    if (flush) begin
      fill_after = '0;
    end else if (is_put) begin
      fill_after = fill_now + brfb_pkg::PTR_W'(moved);
    end else if (is_get) begin
      fill_after = fill_now - brfb_pkg::PTR_W'(moved);
    end else begin
      fill_after = fill_now;
    end
    // free = RING_BYTES - 1 - fill, which is the bitwise complement in PTR_W bits
    fill_ext = {{brfb_pkg::CNT_W{1'b0}}, fill_after};
    free_ext = {{brfb_pkg::CNT_W{1'b0}}, ~fill_after};

    info_nxt.valid   = accept;
    info_nxt.is_get  = is_get;
    info_nxt.moved   = moved;
    info_nxt.refused = refused;
    info_nxt.fill    = fill_ext[brfb_pkg::CNT_W-1:0];
    info_nxt.free    = free_ext[brfb_pkg::CNT_W-1:0];
    info_nxt.rot     = rp_r[brfb_pkg::LANE_W-1:0];

    // byte k of the beat lands in bank (base + k) mod NUM_LANES
    base = is_get ? rp_r : wp_r;
    for (int i = 0; i < brfb_pkg::NUM_LANES; i++) begin
      k    = brfb_pkg::LANE_W'(i) - base[brfb_pkg::LANE_W-1:0];
      addr = base + brfb_pkg::PTR_W'(k);
      req_nxt[i].row   = addr[brfb_pkg::PTR_W-1:brfb_pkg::LANE_W];
      req_nxt[i].wbyte = write_data[{k, 3'b000} +: 8];
      req_nxt[i].we    = accept && is_put && (brfb_pkg::LEN_W'(k) < moved);
      req_nxt[i].re    = accept && is_get && (brfb_pkg::LEN_W'(k) < moved);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      req_r  <= '0;
      info_r <= '0;
    end else begin
      wp_r   <= wp_nxt;
      rp_r   <= rp_nxt;
      req_r  <= req_nxt;
      info_r <= info_nxt;
    end
  end

  assign lane_req = req_r;
  assign info     = info_r;

endmodule

// ----- design/brfb_merge.sv -----
// Merge stage: rotates the bank read bytes into beat order and masks unused lanes.
`timescale 1ns / 1ps
module brfb_merge (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  brfb_pkg::res_info_t                     info,
  input  logic [brfb_pkg::NUM_LANES-1:0][7:0]     lane_rdata,
  output logic                                    out_valid,
  output logic [brfb_pkg::LEN_W-1:0]              out_moved_count,
  output logic [brfb_pkg::DATA_W-1:0]             out_read_data,
  output logic                                    out_refused,
  output logic [brfb_pkg::CNT_W-1:0]              out_fill_count,
  output logic [brfb_pkg::CNT_W-1:0]              out_free_space
);

  brfb_pkg::res_info_t info_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      info_r <= '0;
    end else begin
      info_r <= info;
    end
  end

  always_comb begin
    logic [brfb_pkg::LANE_W-1:0] idx;
    for (int j = 0; j < brfb_pkg::NUM_LANES; j++) begin
      idx = info_r.rot + brfb_pkg::LANE_W'(j);
      out_read_data[8*j +: 8] =
        (info_r.is_get && (brfb_pkg::LEN_W'(j) < info_r.moved)) ? lane_rdata[idx] : 8'h00;
    end
  end

  assign out_valid       = info_r.valid;
  assign out_moved_count = info_r.moved;
  assign out_refused     = info_r.refused;
  assign out_fill_count  = info_r.fill;
  assign out_free_space  = info_r.free;

endmodule

// ----- design/byte_ring_fifo_burst_unit.sv -----
// Top level of the byte ring FIFO: control, eight byte banks and the merge stage.
// A result passes the control, then the bank/merge registers; it shows for one cycle.
// Throughput: one command per cycle; busy stays low, since each beat touches every
//   byte bank at most once and bank accesses happen in command order.
// Reset: synchronous active-low rst_n clears both pointers and the result pipeline;
//   bank contents are not cleared. The receiver cannot stall the result strobe.
`timescale 1ns / 1ps
module byte_ring_fifo_burst_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [brfb_pkg::CMD_W-1:0]     in_command,
  input  logic [brfb_pkg::LEN_W-1:0]     in_burst_length,
  input  logic [brfb_pkg::DATA_W-1:0]    in_write_data,
  output logic                           out_valid,
  output logic [brfb_pkg::LEN_W-1:0]     out_moved_count,
  output logic [brfb_pkg::DATA_W-1:0]    out_read_data,
  output logic                           out_refused,
  output logic [brfb_pkg::CNT_W-1:0]     out_fill_count,
  output logic [brfb_pkg::CNT_W-1:0]     out_free_space
);

  brfb_pkg::lane_req_t [brfb_pkg::NUM_LANES-1:0] lane_req;
  brfb_pkg::res_info_t                           info;
  logic [brfb_pkg::NUM_LANES-1:0][7:0]           lane_rdata;

  assign busy = 1'b0;

  brfb_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (start && !busy),
    .command      (in_command),
    .burst_length (in_burst_length),
    .write_data   (in_write_data),
    .lane_req     (lane_req),
    .info         (info)
  );

  for (genvar g = 0; g < brfb_pkg::NUM_LANES; g++) begin : g_lane
    brfb_lane u_lane (
      .clk   (clk),
      .req   (lane_req[g]),
      .rdata (lane_rdata[g])
    );
  end

  brfb_merge u_merge (
    .clk             (clk),
    .rst_n           (rst_n),
    .info            (info),
    .lane_rdata      (lane_rdata),
    .out_valid       (out_valid),
    .out_moved_count (out_moved_count),
    .out_read_data   (out_read_data),
    .out_refused     (out_refused),
    .out_fill_count  (out_fill_count),
    .out_free_space  (out_free_space)
  );

endmodule

// ----- design/brfb_checker.sv -----
// Port-level checker for the byte ring FIFO, bound to the top level.
`timescale 1ns / 1ps
module brfb_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic                           out_valid,
  input logic [brfb_pkg::LEN_W-1:0]     out_moved_count,
  input logic                           out_refused,
  input logic [brfb_pkg::CNT_W-1:0]     out_fill_count,
  input logic [brfb_pkg::CNT_W-1:0]     out_free_space
);

  // every command taken gets its result strobe after the control and bank/merge registers
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("missing result beat");

  // no result beat without a command taken before it
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result beat without command");

  a_refused_moves_nothing: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_refused) |-> (out_moved_count == '0))
    else $error("refused beat moved bytes");

  // one slot always stays empty: fill + free is the ring size less one
  a_fill_free_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (brfb_pkg::CNT_W'(out_fill_count + out_free_space) ==
                   brfb_pkg::CNT_W'(brfb_pkg::RING_BYTES - 1)))
    else $error("fill and free disagree");

endmodule

bind byte_ring_fifo_burst_unit brfb_checker u_brfb_checker (.*);

// ----- verif/tb_top.sv -----
// Self-checking bench for the byte ring FIFO: directed and random command beats against a ring tracker.
`timescale 1ns / 1ps
module tb_top;

  // command codes the block ignores
  localparam logic [brfb_pkg::CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [brfb_pkg::CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

  localparam int RANDOM_ITEMS = 1400;
  localparam int QUIET_TAIL   = 150;

  typedef struct packed {
    logic [brfb_pkg::LEN_W-1:0]  moved;
    logic [brfb_pkg::DATA_W-1:0] rdata;
    logic                        refused;
    logic [brfb_pkg::CNT_W-1:0]  fill;
    logic [brfb_pkg::CNT_W-1:0]  free;
  } ring_resp_t;

  // Tracks ring contents and pointers, queues the response each command should give.
  class ring_tracker;
    logic [7:0]                 ring_bytes [brfb_pkg::RING_BYTES];
    logic [brfb_pkg::PTR_W-1:0] wr_ptr;
    logic [brfb_pkg::PTR_W-1:0] rd_ptr;
    ring_resp_t                 due_results [$];
    int                         errors;

    function new();
      wr_ptr = '0;
      rd_ptr = '0;
      errors = 0;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function logic [brfb_pkg::PTR_W-1:0] bytes_held();
      logic [brfb_pkg::PTR_W-1:0] d;
      d = wr_ptr - rd_ptr;
      return d;
    endfunction

    function logic [brfb_pkg::PTR_W-1:0] room_left();
      logic [brfb_pkg::PTR_W-1:0] d;
      d = rd_ptr - wr_ptr - 1'b1;
      return d;
    endfunction

    function void push_bytes(logic [brfb_pkg::DATA_W-1:0] wdata, int unsigned n);
      logic [brfb_pkg::PTR_W-1:0] slot;
      slot = wr_ptr;
      for (int i = 0; i < n; i++) begin
        ring_bytes[slot] = wdata[8*i +: 8];
        slot++;
      end
      wr_ptr = slot;
    endfunction

    function logic [brfb_pkg::DATA_W-1:0] pop_bytes(int unsigned n);
      logic [brfb_pkg::PTR_W-1:0]  slot;
      logic [brfb_pkg::DATA_W-1:0] v;
      v = '0;
      slot = rd_ptr;
      for (int i = 0; i < n; i++) begin
        v[8*i +: 8] = ring_bytes[slot];
        slot++;
      end
      rd_ptr = slot;
      return v;
    endfunction

    function void note_command(logic [brfb_pkg::CMD_W-1:0] cmd,
                               logic [brfb_pkg::LEN_W-1:0] blen,
                               logic [brfb_pkg::DATA_W-1:0] wdata);
      ring_resp_t  r;
      int unsigned n;
      int unsigned m;
      r = '0;
      n = (blen > brfb_pkg::MAX_BURST) ? brfb_pkg::MAX_BURST : blen;
      case (cmd)
        brfb_pkg::CMD_PUT: begin
          m = (n < room_left()) ? n : room_left();
          push_bytes(wdata, m);
          r.moved = brfb_pkg::LEN_W'(m);
        end
        brfb_pkg::CMD_PUT_EXACT: begin
          if (room_left() >= n) begin
            push_bytes(wdata, n);
            r.moved = brfb_pkg::LEN_W'(n);
          end else begin
            r.refused = 1'b1;
          end
        end
        brfb_pkg::CMD_GET: begin
          m = (n < bytes_held()) ? n : bytes_held();
          r.rdata = pop_bytes(m);
          r.moved = brfb_pkg::LEN_W'(m);
        end
        brfb_pkg::CMD_GET_EXACT: begin
          if (bytes_held() >= n) begin
            r.rdata = pop_bytes(n);
            r.moved = brfb_pkg::LEN_W'(n);
          end else begin
            r.refused = 1'b1;
          end
        end
        brfb_pkg::CMD_FLUSH: begin
          wr_ptr = '0;
          rd_ptr = '0;
        end
        default: ;
      endcase
      r.fill = brfb_pkg::CNT_W'(bytes_held());
      r.free = brfb_pkg::CNT_W'(room_left());
      due_results.push_back(r);
    endfunction

    function void check_response(logic [brfb_pkg::LEN_W-1:0] moved,
                                 logic [brfb_pkg::DATA_W-1:0] rdata,
                                 logic refused, logic [brfb_pkg::CNT_W-1:0] fill,
                                 logic [brfb_pkg::CNT_W-1:0] free);
      ring_resp_t e;
      if (due_results.size() == 0) begin
        $error("result beat with no command outstanding");
        errors++;
        return;
      end
      e = due_results.pop_front();
      if (moved !== e.moved) begin
        $error("moved_count: expected %0d, got %0d", e.moved, moved);
        errors++;
      end
      if (rdata !== e.rdata) begin
        $error("read_data: expected %h, got %h", e.rdata, rdata);
        errors++;
      end
      if (refused !== e.refused) begin
        $error("refused: expected %0d, got %0d", e.refused, refused);
        errors++;
      end
      if (fill !== e.fill) begin
        $error("fill_count: expected %0d, got %0d", e.fill, fill);
        errors++;
      end
      if (free !== e.free) begin
        $error("free_space: expected %0d, got %0d", e.free, free);
        errors++;
      end
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        start = 1'b0;
  logic                        busy;
  logic [brfb_pkg::CMD_W-1:0]  in_command = brfb_pkg::CMD_FLUSH;
  logic [brfb_pkg::LEN_W-1:0]  in_burst_length = '0;
  logic [brfb_pkg::DATA_W-1:0] in_write_data = '0;
  logic                        out_valid;
  logic [brfb_pkg::LEN_W-1:0]  out_moved_count;
  logic [brfb_pkg::DATA_W-1:0] out_read_data;
  logic                        out_refused;
  logic [brfb_pkg::CNT_W-1:0]  out_fill_count;
  logic [brfb_pkg::CNT_W-1:0]  out_free_space;

  ring_tracker tracker = new();
  bit          idle_on = 1'b1;

  byte_ring_fifo_burst_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_burst_length (in_burst_length),
    .in_write_data   (in_write_data),
    .out_valid       (out_valid),
    .out_moved_count (out_moved_count),
    .out_read_data   (out_read_data),
    .out_refused     (out_refused),
    .out_fill_count  (out_fill_count),
    .out_free_space  (out_free_space)
  );

  always #5 clk = ~clk;

  // accepted command beats feed the tracker, result beats are checked against it
  always @(posedge clk) begin
    if (rst_n && start && !busy)
      tracker.note_command(in_command, in_burst_length, in_write_data);
    if (rst_n && out_valid)
      tracker.check_response(out_moved_count, out_read_data, out_refused,
                             out_fill_count, out_free_space);
  end

  task automatic send_beat(input logic [brfb_pkg::CMD_W-1:0] cmd,
                           input logic [brfb_pkg::LEN_W-1:0] blen,
                           input logic [brfb_pkg::DATA_W-1:0] wdata);
    start           <= 1'b1;
    in_command      <= cmd;
    in_burst_length <= blen;
    in_write_data   <= wdata;
    do @(posedge clk); while (busy);
    if (idle_on && $urandom_range(0, 99) < 15) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // hold off the sender until every outstanding response is back, within a bound
  task automatic wait_responses();
    int guard;
    guard = 0;
    start <= 1'b0;
    do begin
      @(posedge clk);
      guard++;
    end while (tracker.pending() != 0 && guard < 1000);
    if (tracker.pending() != 0) begin
      $error("%0d responses never arrived", tracker.pending());
      tracker.errors++;
    end
  endtask

  logic [brfb_pkg::CMD_W-1:0] cmd;
  logic [brfb_pkg::LEN_W-1:0] blen;
  int unsigned                done_items;
  int unsigned                phase;
  int unsigned                phase_left;
  int unsigned                put_pct;
  int unsigned                roll;
  bit                         paused;

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty ring, zero and long bursts, exact refusals, ignored codes, flush
    send_beat(brfb_pkg::CMD_GET, 4'd4, '0);
    send_beat(brfb_pkg::CMD_GET_EXACT, 4'd1, '0);
    send_beat(brfb_pkg::CMD_GET_EXACT, 4'd0, '0);
    send_beat(brfb_pkg::CMD_PUT, 4'd0, {$urandom, $urandom});
    send_beat(brfb_pkg::CMD_PUT, 4'd8, '1);
    send_beat(brfb_pkg::CMD_PUT, 4'd15, {$urandom, $urandom});
    send_beat(brfb_pkg::CMD_PUT_EXACT, 4'd8, '0);
    send_beat(brfb_pkg::CMD_PUT_EXACT, 4'd3, {8{8'hA5}});
    send_beat(CMD_UNUSED_LO, 4'd8, '1);
    send_beat(CMD_UNUSED_LO + 3'd1, 4'd15, '1);
    send_beat(CMD_UNUSED_HI, 4'd3, '1);
    send_beat(brfb_pkg::CMD_GET, 4'd8, '1);
    send_beat(brfb_pkg::CMD_GET_EXACT, 4'd12, '0);
    send_beat(brfb_pkg::CMD_GET_EXACT, 4'd8, '0);
    send_beat(brfb_pkg::CMD_GET, 4'd15, '0);
    send_beat(brfb_pkg::CMD_GET_EXACT, 4'd1, '0);
    send_beat(brfb_pkg::CMD_PUT_EXACT, 4'd0, '1);
    send_beat(brfb_pkg::CMD_PUT, 4'd5, {$urandom, $urandom});
    send_beat(brfb_pkg::CMD_FLUSH, 4'd8, '1);
    send_beat(brfb_pkg::CMD_GET, 4'd8, '0);
    send_beat(brfb_pkg::CMD_PUT, 4'd1, 64'h0000_0000_0000_0080);
    send_beat(brfb_pkg::CMD_GET_EXACT, 4'd9, '0);
    send_beat(brfb_pkg::CMD_GET_EXACT, 4'd1, '0);

    // random: long fill / drain / mixed stretches so the ring hits full, empty and wraps
    done_items = 0;
    phase_left = 0;
    paused = 1'b0;
    while (done_items < RANDOM_ITEMS) begin
      if (phase_left == 0) begin
        phase      = $urandom_range(0, 2);
        phase_left = $urandom_range(50, 300);
        idle_on    = ($urandom_range(0, 3) != 0);
      end
      if (done_items >= RANDOM_ITEMS - QUIET_TAIL)
        idle_on = 1'b0;
      if (!paused && done_items >= RANDOM_ITEMS / 2) begin
        wait_responses();
        paused = 1'b1;
      end

      put_pct = (phase == 0) ? 85 : (phase == 1) ? 15 : 50;
      roll = $urandom_range(0, 999);
      if (roll < 5)
        cmd = brfb_pkg::CMD_FLUSH;
      else if (roll < 25)
        cmd = brfb_pkg::CMD_W'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
      else if ($urandom_range(0, 99) < put_pct)
        cmd = $urandom_range(0, 1) ? brfb_pkg::CMD_PUT_EXACT : brfb_pkg::CMD_PUT;
      else
        cmd = $urandom_range(0, 1) ? brfb_pkg::CMD_GET_EXACT : brfb_pkg::CMD_GET;

      roll = $urandom_range(0, 99);
      if (roll < 5)
        blen = '0;
      else if (roll < 15)
        blen = brfb_pkg::LEN_W'($urandom_range(brfb_pkg::MAX_BURST + 1, 15));
      else if (phase == 2)
        blen = brfb_pkg::LEN_W'($urandom_range(1, brfb_pkg::MAX_BURST));
      else
        blen = brfb_pkg::LEN_W'($urandom_range(3, brfb_pkg::MAX_BURST));

      send_beat(cmd, blen, {$urandom, $urandom});
      if (cmd < CMD_UNUSED_LO)
        done_items++;
      phase_left--;
    end

    wait_responses();
    repeat (4) @(posedge clk);
    if (tracker.errors == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/brfb_pkg.sv
design/brfb_lane.sv
design/brfb_ctrl.sv
design/brfb_merge.sv
design/byte_ring_fifo_burst_unit.sv
design/brfb_checker.sv
verif/tb_top.sv
